// File: hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every rising aclk outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// implication checked in the same cycle
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/lse_pkg.sv
`default_nettype none

package lse_pkg;

    localparam int DATA_W              = 32;
    localparam int OPCODE_W            = 3;
    localparam int STATUS_W            = 2;
    localparam int M_USER_W            = STATUS_W + 1;
    localparam int DEFAULT_STACK_DEPTH = 64;

    localparam logic [OPCODE_W-1:0] OP_PUSH = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_DUMP = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_PEEK = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_POP  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_SWAP = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SHORT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    // read address select
    localparam logic [1:0] RD_TOP     = 2'd0;
    localparam logic [1:0] RD_SECOND  = 2'd1;
    localparam logic [1:0] RD_IDX_DEC = 2'd2;

    // write select
    localparam logic [1:0] WR_NONE   = 2'd0;
    localparam logic [1:0] WR_PUSH   = 2'd1;
    localparam logic [1:0] WR_TOP    = 2'd2;
    localparam logic [1:0] WR_SECOND = 2'd3;

    typedef struct packed {
        logic                rd_en;
        logic [1:0]          rd_sel;
        logic [1:0]          wr_sel;
        logic                cnt_inc;
        logic                cnt_dec;
        logic                idx_load;
        logic                idx_dec;
        logic                tmp_save;
        logic                out_load;
        logic                out_has;
        logic [STATUS_W-1:0] out_status;
        logic                out_last;
    } lse_cmd_t;

    typedef struct packed {
        logic out_free;
        logic empty;
        logic full;
        logic few_entries;
        logic idx_zero;
    } lse_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/lse_ram.sv
`default_nettype none

module lse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/lse_ctrl.sv
`default_nettype none

module lse_ctrl (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    input  wire logic [lse_pkg::OPCODE_W-1:0]  opcode,
    output logic                               s_ready,
    input  wire lse_pkg::lse_stat_t            stat,
    output lse_pkg::lse_cmd_t                  cmd
);

    import lse_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_PEEK     = 3'd1;
    localparam logic [2:0] S_SWAP_RD  = 3'd2;
    localparam logic [2:0] S_SWAP_WR  = 3'd3;
    localparam logic [2:0] S_SWAP_FIN = 3'd4;
    localparam logic [2:0] S_DUMP     = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.out_status = ST_OK;
        s_ready        = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = stat.out_free;
                if (s_valid && stat.out_free) begin
                    cmd.out_last = 1'b1;
                    unique case (opcode)
                        OP_PUSH: begin
                            cmd.out_load = 1'b1;
                            if (stat.full) begin
                                cmd.out_status = ST_FULL;
                            end else begin
                                cmd.wr_sel  = WR_PUSH;
                                cmd.cnt_inc = 1'b1;
                            end
                        end
                        OP_DUMP: begin
                            if (stat.empty) begin
                                cmd.out_load = 1'b1;
                            end else begin
                                cmd.rd_en    = 1'b1;
                                cmd.rd_sel   = RD_TOP;
                                cmd.idx_load = 1'b1;
                                state_next   = S_DUMP;
                            end
                        end
                        OP_PEEK: begin
                            if (stat.empty) begin
                                cmd.out_load   = 1'b1;
                                cmd.out_status = ST_EMPTY;
                            end else begin
                                cmd.rd_en  = 1'b1;
                                cmd.rd_sel = RD_TOP;
                                state_next = S_PEEK;
                            end
                        end
                        OP_POP: begin
                            cmd.out_load = 1'b1;
                            if (stat.empty) begin
                                cmd.out_status = ST_EMPTY;
                            end else begin
                                cmd.cnt_dec = 1'b1;
                            end
                        end
                        OP_SWAP: begin
                            if (stat.few_entries) begin
                                cmd.out_load   = 1'b1;
                                cmd.out_status = ST_SHORT;
                            end else begin
                                cmd.rd_en  = 1'b1;
                                cmd.rd_sel = RD_TOP;
                                state_next = S_SWAP_RD;
                            end
                        end
                        default: begin
                            cmd.out_load = 1'b1;
                        end
                    endcase
                end
            end
            S_PEEK: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_has  = 1'b1;
                    cmd.out_last = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_SWAP_RD: begin
                cmd.tmp_save = 1'b1;
                cmd.rd_en    = 1'b1;
                cmd.rd_sel   = RD_SECOND;
                state_next   = S_SWAP_WR;
            end
            S_SWAP_WR: begin
                cmd.wr_sel = WR_TOP;
                state_next = S_SWAP_FIN;
            end
            S_SWAP_FIN: begin
                cmd.wr_sel = WR_SECOND;
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_DUMP: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_has  = 1'b1;
                    cmd.out_last = stat.idx_zero;
                    if (stat.idx_zero) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.idx_dec = 1'b1;
                        cmd.rd_en   = 1'b1;
                        cmd.rd_sel  = RD_IDX_DEC;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/lse_datapath.sv
`default_nettype none

module lse_datapath #(
    parameter int STACK_DEPTH = lse_pkg::DEFAULT_STACK_DEPTH
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic [lse_pkg::DATA_W-1:0]   push_value,
    input  wire lse_pkg::lse_cmd_t            cmd,
    output lse_pkg::lse_stat_t                stat,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic      [lse_pkg::DATA_W-1:0]   m_data,
    output logic      [lse_pkg::M_USER_W-1:0] m_user,
    output logic                              m_last
);

    import lse_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic [CW-1:0]       cnt_m1;
    logic [CW-1:0]       cnt_m2;
    logic [AW-1:0]       idx_reg;
    logic [AW-1:0]       idx_m1;
    logic [DATA_W-1:0]   tmp_reg;
    logic [DATA_W-1:0]   rd_data;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [DATA_W-1:0]   wr_data;
    logic [AW-1:0]       rd_addr;
    logic                m_valid_reg;
    logic [DATA_W-1:0]   m_data_reg;
    logic [M_USER_W-1:0] m_user_reg;
    logic                m_last_reg;

    assign cnt_m1 = count_reg - CW'(1);
    assign cnt_m2 = count_reg - CW'(2);
    assign idx_m1 = idx_reg - AW'(1);

    assign stat.out_free    = !m_valid_reg || m_ready;
    assign stat.empty       = (count_reg == '0);
    assign stat.full        = (count_reg == CW'(STACK_DEPTH));
    assign stat.few_entries = (count_reg < CW'(2));
    assign stat.idx_zero    = (idx_reg == '0);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = count_reg[AW-1:0];
        wr_data = push_value;
        unique case (cmd.wr_sel)
            WR_PUSH: begin
                wr_en = 1'b1;
            end
            WR_TOP: begin
                wr_en   = 1'b1;
                wr_addr = cnt_m1[AW-1:0];
                wr_data = rd_data;
            end
            WR_SECOND: begin
                wr_en   = 1'b1;
                wr_addr = cnt_m2[AW-1:0];
                wr_data = tmp_reg;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        unique case (cmd.rd_sel)
            RD_TOP:     rd_addr = cnt_m1[AW-1:0];
            RD_SECOND:  rd_addr = cnt_m2[AW-1:0];
            RD_IDX_DEC: rd_addr = idx_m1;
            default:    rd_addr = cnt_m1[AW-1:0];
        endcase
    end

    lse_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        count_next = count_reg;
        if (cmd.cnt_inc) begin
            count_next = count_reg + CW'(1);
        end else if (cmd.cnt_dec) begin
            count_next = cnt_m1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.idx_load) begin
            idx_reg <= cnt_m1[AW-1:0];
        end else if (cmd.idx_dec) begin
            idx_reg <= idx_m1;
        end
        if (cmd.tmp_save) begin
            tmp_reg <= rd_data;
        end
        if (cmd.out_load) begin
            m_data_reg <= cmd.out_has ? rd_data : '0;
            m_user_reg <= {cmd.out_status, cmd.out_has};
            m_last_reg <= cmd.out_last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign m_user  = m_user_reg;
    assign m_last  = m_last_reg;

endmodule

`default_nettype wire

// File: hw/rtl/lifo_stack_engine_unit.sv
// lifo stack of signed 32-bit entries, one command per slave transaction
// slave side: s_axis_tuser carries the opcode (push, dump, peek, pop, swap),
//   s_axis_tdata the value stored by push
// master side: one or more result transactions per command;
//   m_axis_tlast marks the final one, m_axis_tuser carries has_value and status
// a command is taken only while the output register is empty or being drained
// push, pop and failed or no-op commands: result registered, valid next cycle
// peek: one registered ram read (state S_PEEK) before the result
// swap: two reads and two writes through the single-port-pair ram
// dump of n entries: a read of the top entry first, then one entry per cycle
//   while the master is not stalling, top first
// a master stall holds the result; the sequencer waits in its result-loading states until taken
// reset empties the stack at once; ram contents need no clearing
`default_nettype none
`include "assert_macros.svh"

module lifo_stack_engine_unit #(
    parameter int STACK_DEPTH = lse_pkg::DEFAULT_STACK_DEPTH
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    // push_value
    input  wire logic [lse_pkg::DATA_W-1:0]   s_axis_tdata,
    // opcode
    input  wire logic [lse_pkg::OPCODE_W-1:0] s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // result_value
    output logic      [lse_pkg::DATA_W-1:0]   m_axis_tdata,
    // has_value, status
    output logic      [lse_pkg::M_USER_W-1:0] m_axis_tuser,
    output logic                              m_axis_tlast
);

    import lse_pkg::*;

    lse_cmd_t  cmd;
    lse_stat_t stat;

    lse_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .opcode  (s_axis_tuser),
        .s_ready (s_axis_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    lse_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_value (s_axis_tdata),
        .cmd        (cmd),
        .stat       (stat),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .m_data     (m_axis_tdata),
        .m_user     (m_axis_tuser),
        .m_last     (m_axis_tlast)
    );

    `ASSERT_IMPLIES(a_ready_out_free, s_axis_tready,
                    !m_axis_tvalid || m_axis_tready, "ready with output busy")
    `ASSERT_IMPLIES(a_load_out_free, cmd.out_load, stat.out_free, "result overwritten")
    `ASSERT_IMPLIES(a_no_push_full, cmd.wr_sel == WR_PUSH, !stat.full, "push on full stack")
    `ASSERT_IMPLIES(a_value_ok, m_axis_tvalid && m_axis_tuser[0],
                    m_axis_tuser[2:1] == ST_OK, "value with error status")
    `ASSERT_ALWAYS(a_inc_dec_excl, !(cmd.cnt_inc && cmd.cnt_dec), "count up and down together")

endmodule

`default_nettype wire

// File: verif/tb.sv
`default_nettype none

module tb;
    import lse_pkg::*;

    localparam int DEPTH = DEFAULT_STACK_DEPTH;
    localparam logic [OPCODE_W-1:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_UNUSED_MID   = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_UNUSED_LAST  = 3'd7;
    localparam int ITEM_TARGET = 370;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     has_value;
        logic [STATUS_W-1:0]      status;
        logic                     last;
    } stack_result_t;

    typedef enum {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

    class lifo_tracker;
        logic signed [DATA_W-1:0] entries [DEPTH];
        int unsigned              depth_used;
        stack_result_t            pending_results[$];
        int unsigned              mismatches;

        function new();
            depth_used = 0;
            mismatches = 0;
        endfunction

        function void add_result(logic signed [DATA_W-1:0] value, logic has_value,
                                 logic [STATUS_W-1:0] status, logic last);
            stack_result_t r;
            r.value     = value;
            r.has_value = has_value;
            r.status    = status;
            r.last      = last;
            pending_results.push_back(r);
        endfunction

        function void apply_command(logic [OPCODE_W-1:0] op, logic signed [DATA_W-1:0] value);
            int idx;
            logic signed [DATA_W-1:0] held;
            case (op)
                OP_PUSH: begin
                    if (depth_used >= DEPTH) begin
                        add_result('0, 1'b0, ST_FULL, 1'b1);
                    end else begin
                        entries[depth_used] = value;
                        depth_used++;
                        add_result('0, 1'b0, ST_OK, 1'b1);
                    end
                end
                OP_DUMP: begin
                    if (depth_used == 0) begin
                        add_result('0, 1'b0, ST_OK, 1'b1);
                    end else begin
                        for (idx = depth_used - 1; idx >= 0; idx--)
                            add_result(entries[idx], 1'b1, ST_OK, idx == 0);
                    end
                end
                OP_PEEK: begin
                    if (depth_used == 0)
                        add_result('0, 1'b0, ST_EMPTY, 1'b1);
                    else
                        add_result(entries[depth_used-1], 1'b1, ST_OK, 1'b1);
                end
                OP_POP: begin
                    if (depth_used == 0) begin
                        add_result('0, 1'b0, ST_EMPTY, 1'b1);
                    end else begin
                        depth_used--;
                        add_result('0, 1'b0, ST_OK, 1'b1);
                    end
                end
                OP_SWAP: begin
                    if (depth_used < 2) begin
                        add_result('0, 1'b0, ST_SHORT, 1'b1);
                    end else begin
                        held                  = entries[depth_used-1];
                        entries[depth_used-1] = entries[depth_used-2];
                        entries[depth_used-2] = held;
                        add_result('0, 1'b0, ST_OK, 1'b1);
                    end
                end
                default: begin
                    add_result('0, 1'b0, ST_OK, 1'b1);
                end
            endcase
        endfunction

        function void compare_result(logic [DATA_W-1:0] data, logic [M_USER_W-1:0] user,
                                     logic last);
            stack_result_t want;
            if (pending_results.size() == 0) begin
                $error("unexpected result transaction: tdata=%h tuser=%b tlast=%b",
                       data, user, last);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            if (data !== want.value) begin
                $error("result_value: expected %0d, actual %0d", want.value, $signed(data));
                mismatches++;
            end
            if (user[0] !== want.has_value) begin
                $error("has_value: expected %0d, actual %0d", want.has_value, user[0]);
                mismatches++;
            end
            if (user[M_USER_W-1:1] !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, user[M_USER_W-1:1]);
                mismatches++;
            end
            if (last !== want.last) begin
                $error("last: expected %0d, actual %0d", want.last, last);
                mismatches++;
            end
        endfunction
    endclass

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [DATA_W-1:0]     s_axis_tdata  = '0;
    logic [OPCODE_W-1:0]   s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [DATA_W-1:0]     m_axis_tdata;
    logic [M_USER_W-1:0]   m_axis_tuser;
    logic                  m_axis_tlast;

    lifo_tracker tracker = new();
    int          burst_left;
    int          items_sent;
    rx_mode_t    rx_mode;
    int          rx_mode_left;

    lifo_stack_engine_unit #(
        .STACK_DEPTH(DEPTH)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 aclk = ~aclk;

    // receiver stall pattern
    always @(negedge aclk) begin
        if (rx_mode_left == 0) begin
            rx_mode      = rx_mode_t'($urandom_range(3, 0));
            rx_mode_left = $urandom_range(300, 40);
        end
        rx_mode_left--;
        case (rx_mode)
            RX_ALWAYS:   m_axis_tready <= 1'b1;
            RX_COIN:     m_axis_tready <= 1'($urandom_range(1, 0));
            RX_SPARSE:   m_axis_tready <= ($urandom_range(3, 0) == 0);
            RX_PERIODIC: m_axis_tready <= ((rx_mode_left % 8) < 5);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            tracker.compare_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    function automatic logic [DATA_W-1:0] random_word();
        case ($urandom_range(7, 0))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_command(input logic [OPCODE_W-1:0] op, input logic [DATA_W-1:0] value);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(8, 1);
            @(negedge aclk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
            burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(60, 20)
                                                      : $urandom_range(10, 1);
        end
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= value;
        do @(posedge aclk); while (!s_axis_tready);
        tracker.apply_command(op, value);
        burst_left--;
        items_sent++;
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (tracker.pending_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic send_mixed(input int count);
        int r;
        repeat (count) begin
            r = $urandom_range(99, 0);
            if (r < 35)
                send_command(OP_PUSH, random_word());
            else if (r < 43)
                send_command(OP_DUMP, random_word());
            else if (r < 57)
                send_command(OP_PEEK, random_word());
            else if (r < 80)
                send_command(OP_POP, random_word());
            else if (r < 94)
                send_command(OP_SWAP, random_word());
            else
                send_command(OPCODE_W'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST)),
                             random_word());
        end
    endtask

    task automatic fill_stack();
        while (tracker.depth_used < DEPTH)
            send_command(OP_PUSH, random_word());
        repeat ($urandom_range(3, 1))
            send_command(OP_PUSH, random_word());
        send_command(OP_DUMP, random_word());
        send_command(OP_SWAP, random_word());
        send_command(OP_PEEK, random_word());
    endtask

    task automatic empty_stack();
        while (tracker.depth_used > 0)
            send_command(OP_POP, random_word());
        repeat ($urandom_range(2, 1))
            send_command(OP_POP, random_word());
        send_command(OP_PEEK, random_word());
        send_command(OP_SWAP, random_word());
        send_command(OP_DUMP, random_word());
    endtask

    initial begin
        int phase;
        burst_left = 0;
        items_sent = 0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // empty stack, single entry, extremes, every opcode
        send_command(OP_DUMP, random_word());
        send_command(OP_POP,  random_word());
        send_command(OP_PEEK, random_word());
        send_command(OP_SWAP, random_word());
        send_command(OP_PUSH, 32'h8000_0000);
        send_command(OP_SWAP, random_word());
        send_command(OP_PEEK, random_word());
        send_command(OP_PUSH, 32'h7fff_ffff);
        send_command(OP_PUSH, 32'h0000_0000);
        send_command(OP_PUSH, 32'hffff_ffff);
        send_command(OP_PEEK, random_word());
        send_command(OP_SWAP, random_word());
        send_command(OP_PEEK, random_word());
        send_command(OP_DUMP, random_word());
        send_command(OP_UNUSED_FIRST, random_word());
        send_command(OP_UNUSED_MID, random_word());
        send_command(OP_UNUSED_LAST, random_word());
        repeat (4) send_command(OP_POP, random_word());
        send_command(OP_POP, random_word());
        send_command(OP_DUMP, random_word());
        drain_results();

        fill_stack();
        while (items_sent < ITEM_TARGET) begin
            phase = $urandom_range(9, 0);
            if (phase < 6)
                send_mixed($urandom_range(30, 5));
            else if (phase == 6)
                fill_stack();
            else if (phase < 9)
                empty_stack();
            else
                drain_results();
        end

        drain_results();
        repeat (20) @(posedge aclk);
        if (tracker.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #20000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
